// ===== hdl/lbf_pkg.sv =====
package lbf_pkg;

  // Fade loop constants.
  localparam logic [7:0] Period = 8'd10;
  localparam logic [7:0] Steps  = 8'd10;

  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 16;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_FADE_ENABLE = 2'd0,
    CFG_HOLD_TICKS  = 2'd1,
    CFG_LED_ID      = 2'd2
  } lbf_cfg_e;

  typedef struct packed {
    logic                 valid;
    logic [CfgIndexW-1:0] index;
    logic [CfgDataW-1:0]  data;
  } lbf_cfg_wr_t;

  typedef struct packed {
    logic [3:0] led_select;
    logic       led_on;
    logic [7:0] duty_step;
    logic       fading_up;
  } lbf_result_t;

endpackage

// ===== hdl/lbf_fade_core.sv =====
module lbf_fade_core import lbf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  lbf_cfg_wr_t cfg_wr_i,
  input  logic        item_i,
  input  logic        tick_i,
  output lbf_result_t result_o
);

  logic        fade_enable_q, fade_enable_d;
  logic [15:0] hold_ticks_q, hold_ticks_d;
  logic [3:0]  led_id_q, led_id_d;
  logic [7:0]  step_level_q, step_level_d;
  logic        rising_q, rising_d;
  logic [7:0]  phase_left_q, phase_left_d;
  logic        output_level_q, output_level_d;
  logic [15:0] hold_left_q, hold_left_d;
  logic        toggled;

  always_comb begin
    fade_enable_d  = fade_enable_q;
    hold_ticks_d   = hold_ticks_q;
    led_id_d       = led_id_q;
    step_level_d   = step_level_q;
    rising_d       = rising_q;
    phase_left_d   = phase_left_q;
    output_level_d = output_level_q;
    hold_left_d    = hold_left_q;
    toggled        = ~output_level_q;

    if (cfg_wr_i.valid) begin
      case (cfg_wr_i.index)
        CFG_FADE_ENABLE: begin
          fade_enable_d  = cfg_wr_i.data[0];
          output_level_d = 1'b0;
          if (cfg_wr_i.data[0]) begin
            // Restart from step zero: the LED is off with a full phase.
            step_level_d = 8'd0;
            rising_d     = 1'b1;
            phase_left_d = Period;
            hold_left_d  = hold_ticks_q;
          end
        end
        CFG_HOLD_TICKS: hold_ticks_d = cfg_wr_i.data;
        CFG_LED_ID:     led_id_d     = cfg_wr_i.data[3:0];
        default: ;
      endcase
    end else if (item_i && tick_i && fade_enable_q) begin
      if (hold_left_q == 16'd0) begin
        if (rising_q) begin
          if (step_level_q < Steps) step_level_d = step_level_q + 8'd1;
          else                      rising_d     = 1'b0;
        end else begin
          if (step_level_q != 8'd0) step_level_d = step_level_q - 8'd1;
          else                      rising_d     = 1'b1;
        end
        // Reload the PWM for the new step.
        hold_left_d = hold_ticks_q;
        if (step_level_d == 8'd0) begin
          output_level_d = 1'b0;
          phase_left_d   = Period;
        end else begin
          output_level_d = 1'b1;
          phase_left_d   = step_level_d;
        end
      end else begin
        if (phase_left_q != 8'd0) begin
          phase_left_d = phase_left_q - 8'd1;
        end else if (step_level_q == 8'd0 || step_level_q >= Period) begin
          phase_left_d = Period;
        end else begin
          output_level_d = toggled;
          phase_left_d   = toggled ? step_level_q : Period - step_level_q;
        end
        hold_left_d = hold_left_q - 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_enable_q  <= 1'b0;
      hold_ticks_q   <= 16'd1;
      led_id_q       <= 4'd0;
      step_level_q   <= 8'd0;
      rising_q       <= 1'b1;
      phase_left_q   <= Period;
      output_level_q <= 1'b0;
      hold_left_q    <= 16'd1;
    end else begin
      fade_enable_q  <= fade_enable_d;
      hold_ticks_q   <= hold_ticks_d;
      led_id_q       <= led_id_d;
      step_level_q   <= step_level_d;
      rising_q       <= rising_d;
      phase_left_q   <= phase_left_d;
      output_level_q <= output_level_d;
      hold_left_q    <= hold_left_d;
    end
  end

  // The result reflects the state after this item's update.
  assign result_o.led_select = led_id_d;
  assign result_o.led_on     = fade_enable_d & output_level_d;
  assign result_o.duty_step  = step_level_d;
  assign result_o.fading_up  = rising_d;

endmodule

// ===== hdl/lbf_out_buf.sv =====
module lbf_out_buf import lbf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  lbf_result_t data_i,
  output logic        ready_o,
  output logic        valid_o,
  input  logic        ready_i,
  output lbf_result_t data_o
);

  lbf_result_t slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        pop;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];
  assign pop     = valid_o & ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop;
    count_d  = count_q;
    if (push_i && !pop)      count_d = count_q + 2'd1;
    else if (pop && !push_i) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/led_breathing_fade.sv =====
// Channel  Handshake                 Payload
// in       in_valid_i / in_ready_o   tick_i
// out      out_valid_o / out_ready_i led_select_o, led_on_o, duty_step_o, fading_up_o
// cfg      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item per cycle while in_ready_o is high; its result is registered by the single
// register stage, the output buffer, between the fade state update and the output.
// A two-entry output buffer lets items keep flowing while a result is stalled;
// in_ready_o drops only when both entries are held.
// Reset clears the fade state to step zero, rising, LED off, fade disabled.
// Configuration writes are always taken.
module led_breathing_fade import lbf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 tick_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [3:0]           led_select_o,
  output logic                 led_on_o,
  output logic [7:0]           duty_step_o,
  output logic                 fading_up_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  lbf_cfg_wr_t cfg_wr;
  lbf_result_t core_result;
  lbf_result_t out_result;
  logic        item_accept;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;
  assign item_accept  = in_valid_i & in_ready_o;

  lbf_fade_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_wr_i (cfg_wr),
    .item_i   (item_accept),
    .tick_i   (tick_i),
    .result_o (core_result)
  );

  lbf_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (item_accept),
    .data_i  (core_result),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_result)
  );

  assign led_select_o = out_result.led_select;
  assign led_on_o     = out_result.led_on;
  assign duty_step_o  = out_result.duty_step;
  assign fading_up_o  = out_result.fading_up;

endmodule
